### sv/brb_pkg.sv
// ============================================================================
// brb_pkg
// Shared types, field widths, mode codes and character constants for the
// byte ring buffer with pattern search.
// ============================================================================
package brb_pkg;

    localparam int BRB_DEPTH       = 128;
    localparam int BRB_MAX_PATTERN = 8;

    localparam int MODE_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int OFS_W   = 7;
    localparam int PAT_W   = 64;
    localparam int PLEN_W  = 4;
    localparam int NUM_W   = 32;
    localparam int SLOT_W  = 7;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 64;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CHOP   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_NUMBER = 3'd6;

    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic                  adjust_head;
        logic                  move_to_end;
        logic [PLEN_W-1:0]     pattern_length;
        logic [PAT_W-1:0]      pattern;
        logic [OFS_W-1:0]      offset;
        logic [BYTE_W-1:0]     data_byte;
        logic [MODE_W-1:0]     mode;
    } t_item;

    typedef struct packed {
        logic [1:0]            pad;
        logic [SLOT_W-1:0]     match_end;
        logic [SLOT_W-1:0]     match_start;
        logic [SLOT_W-1:0]     level;
        logic signed [NUM_W-1:0] number;
        logic [BYTE_W-1:0]     data_out;
        logic                  ok;
    } t_result;

endpackage

### sv/brb_ram.sv
// ============================================================================
// brb_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/brb_engine.sv
// ============================================================================
// brb_engine
// Sequencer for the ring buffer: holds head and tail, runs each mode against
// the byte RAM one read per cycle, and presents one result per item.
// ============================================================================
module brb_engine #(
    parameter int DEPTH       = 128,
    parameter int MAX_PATTERN = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  brb_pkg::t_item           i_item,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output brb_pkg::t_result         o_res,
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [7:0]               o_wdata,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    input  logic [7:0]               i_rdata
);
    import brb_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int SW  = ((AW > OFS_W) ? AW : OFS_W) + 1;
    localparam int MW  = AW + PLEN_W;
    localparam int CW  = $clog2(MAX_PATTERN + 1);
    localparam int PW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_PARSE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                         r_state, n_state;
    logic [AW-1:0]                      r_head, n_head;
    logic [AW-1:0]                      r_tail, n_tail;
    logic [AW-1:0]                      r_addr, n_addr;
    logic [AW-1:0]                      r_left, n_left;
    logic [AW-1:0]                      r_dslot, n_dslot;
    logic                               r_rvalid, n_rvalid;
    logic                               r_chop, n_chop;
    logic                               r_mte, n_mte;
    logic                               r_adj, n_adj;
    logic [CW-1:0]                      r_len, n_len;
    logic [CW-1:0]                      r_nb, n_nb;
    logic [MAX_PATTERN-1:0][7:0]        r_pal, n_pal;
    logic [MAX_PATTERN-1:0]             r_msk, n_msk;
    logic [MAX_PATTERN-1:0][7:0]        r_win, n_win;
    logic [NUM_W-1:0]                   r_acc, n_acc;
    logic                               r_any, n_any;
    logic                               r_neg, n_neg;
    logic                               r_ok, n_ok;
    logic [7:0]                         r_dout, n_dout;
    logic [NUM_W-1:0]                   r_num, n_num;
    logic [AW-1:0]                      r_ms, n_ms;
    logic [AW-1:0]                      r_me, n_me;

    logic [AW-1:0]                      w_level;
    logic                               w_empty;
    logic                               w_full;
    logic [PLEN_W-1:0]                  w_plen;
    logic [SW-1:0]                      w_psum;
    logic [AW-1:0]                      w_pslot;
    logic [7:0][7:0]                    w_pbytes;
    logic [MAX_PATTERN-1:0][7:0]        w_win_n;
    logic [MAX_PATTERN-1:0]             w_eq;
    logic [CW-1:0]                      w_nb_inc;
    logic                               w_match;
    logic [MW-1:0]                      w_lm1;
    logic [MW-1:0]                      w_e;
    logic [AW-1:0]                      w_start;
    logic [AW-1:0]                      w_dest;
    logic                               w_is_digit;
    logic [3:0]                         w_digit;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] s);
        return (s == LAST) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] s);
        return (s == '0) ? LAST : s - 1'b1;
    endfunction

    assign w_level = (r_tail >= r_head) ? (r_tail - r_head)
                   : AW'({1'b0, r_tail} + (AW+1)'(DEPTH) - {1'b0, r_head});
    assign w_empty = (r_head == r_tail);
    assign w_full  = (w_level == LAST);
    assign w_plen  = (i_item.pattern_length > PLEN_W'(MAX_PATTERN))
                   ? PLEN_W'(MAX_PATTERN) : i_item.pattern_length;

    assign w_psum  = SW'(r_head) + SW'(i_item.offset);
    assign w_pslot = (w_psum >= SW'(DEPTH)) ? AW'(w_psum - SW'(DEPTH)) : AW'(w_psum);

    assign w_pbytes = i_item.pattern;

    always_comb begin
        w_win_n[0] = i_rdata;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            w_win_n[j] = r_win[j-1];
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            w_eq[j] = (w_win_n[j] == r_pal[j]);
        end
    end

    assign w_nb_inc = (r_nb == CW'(MAX_PATTERN)) ? r_nb : r_nb + 1'b1;
    assign w_match  = r_rvalid && (w_nb_inc >= r_len) && (&(~r_msk | w_eq));

    assign w_lm1   = MW'(r_len) - MW'(1);
    assign w_e     = MW'(r_dslot);
    assign w_start = (w_e >= w_lm1) ? AW'(w_e - w_lm1) : AW'(w_e + MW'(DEPTH) - w_lm1);
    assign w_dest  = r_mte ? f_inc(r_dslot) : w_start;

    assign w_is_digit = (i_rdata >= CHAR_ZERO) && (i_rdata <= CHAR_NINE);
    assign w_digit    = 4'(i_rdata - CHAR_ZERO);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_addr   = r_addr;
        n_left   = r_left;
        n_dslot  = r_dslot;
        n_rvalid = 1'b0;
        n_chop   = r_chop;
        n_mte    = r_mte;
        n_adj    = r_adj;
        n_len    = r_len;
        n_nb     = r_nb;
        n_pal    = r_pal;
        n_msk    = r_msk;
        n_win    = r_win;
        n_acc    = r_acc;
        n_any    = r_any;
        n_neg    = r_neg;
        n_ok     = r_ok;
        n_dout   = r_dout;
        n_num    = r_num;
        n_ms     = r_ms;
        n_me     = r_me;
        o_we     = 1'b0;
        o_waddr  = r_tail;
        o_wdata  = i_item.data_byte;
        o_raddr  = r_addr;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_ok    = 1'b0;
                    n_dout  = '0;
                    n_num   = '0;
                    n_ms    = '0;
                    n_me    = '0;
                    n_nb    = '0;
                    n_acc   = '0;
                    n_any   = 1'b0;
                    n_neg   = 1'b0;
                    n_chop  = (i_item.mode == MODE_CHOP);
                    n_mte   = i_item.move_to_end;
                    n_adj   = i_item.adjust_head;
                    n_len   = CW'(w_plen);
                    for (int j = 0; j < MAX_PATTERN; j++) begin
                        n_msk[j] = (j < int'(w_plen));
                        n_pal[j] = w_pbytes[PW'(int'(w_plen) - 1 - j)];
                    end
                    n_state = ST_DONE;
                    case (i_item.mode)
                        MODE_PUSH: begin
                            if (!w_full) begin
                                o_we   = 1'b1;
                                n_tail = f_inc(r_tail);
                                n_ok   = 1'b1;
                            end
                        end
                        MODE_POP: begin
                            if (!w_empty) begin
                                o_raddr  = r_head;
                                n_rvalid = 1'b1;
                                n_head   = f_inc(r_head);
                                n_state  = ST_READ;
                            end
                        end
                        MODE_PEEK: begin
                            if (SW'(i_item.offset) < SW'(w_level)) begin
                                o_raddr  = w_pslot;
                                n_rvalid = 1'b1;
                                n_state  = ST_READ;
                            end
                        end
                        MODE_FLUSH: begin
                            n_head = r_tail;
                        end
                        MODE_LOCATE, MODE_CHOP: begin
                            if (w_plen == '0) begin
                                n_ok = 1'b1;
                                n_ms = r_head;
                                n_me = f_dec(r_head);
                                if ((i_item.mode == MODE_CHOP) && !i_item.adjust_head) begin
                                    n_tail = r_head;
                                end
                            end else begin
                                n_addr  = r_head;
                                n_left  = w_level;
                                n_state = ST_SCAN;
                            end
                        end
                        MODE_NUMBER: begin
                            if (!w_empty) begin
                                n_addr  = f_inc(r_head);
                                n_left  = w_level - 1'b1;
                                n_state = ST_PARSE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_dout  = i_rdata;
                n_ok    = 1'b1;
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (r_left != '0) begin
                    n_addr   = f_inc(r_addr);
                    n_left   = r_left - 1'b1;
                    n_rvalid = 1'b1;
                    n_dslot  = r_addr;
                end
                if (r_rvalid) begin
                    n_win = w_win_n;
                    n_nb  = w_nb_inc;
                end
                if (w_match) begin
                    n_ok     = 1'b1;
                    n_ms     = w_start;
                    n_me     = r_dslot;
                    n_rvalid = 1'b0;
                    n_state  = ST_DONE;
                    if (r_chop) begin
                        if (r_adj) begin
                            n_head = w_dest;
                        end else begin
                            n_tail = w_dest;
                        end
                    end
                end else if (!r_rvalid && (r_left == '0)) begin
                    n_state = ST_DONE;
                end
            end
            ST_PARSE: begin
                if (r_left != '0) begin
                    n_addr   = f_inc(r_addr);
                    n_left   = r_left - 1'b1;
                    n_rvalid = 1'b1;
                end
                if (r_rvalid) begin
                    if ((i_rdata == CHAR_SPACE) && !r_any) begin
                        n_any = r_any;
                    end else if ((i_rdata == CHAR_MINUS) && !r_any) begin
                        n_neg = 1'b1;
                        n_any = 1'b1;
                    end else if (w_is_digit) begin
                        n_any = 1'b1;
                        n_acc = (r_acc << 3) + (r_acc << 1) + NUM_W'(w_digit);
                    end else begin
                        n_rvalid = 1'b0;
                        n_num    = r_neg ? (NUM_W'(0) - r_acc) : r_acc;
                        n_state  = ST_DONE;
                    end
                end else if (r_left == '0) begin
                    n_num   = r_neg ? (NUM_W'(0) - r_acc) : r_acc;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_rvalid <= n_rvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_left  <= n_left;
        r_dslot <= n_dslot;
        r_chop  <= n_chop;
        r_mte   <= n_mte;
        r_adj   <= n_adj;
        r_len   <= n_len;
        r_nb    <= n_nb;
        r_pal   <= n_pal;
        r_msk   <= n_msk;
        r_win   <= n_win;
        r_acc   <= n_acc;
        r_any   <= n_any;
        r_neg   <= n_neg;
        r_ok    <= n_ok;
        r_dout  <= n_dout;
        r_num   <= n_num;
        r_ms    <= n_ms;
        r_me    <= n_me;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);

    always_comb begin
        o_res             = '0;
        o_res.ok          = r_ok;
        o_res.data_out    = r_dout;
        o_res.number      = r_num;
        o_res.level       = SLOT_W'(w_level);
        o_res.match_start = SLOT_W'(r_ms);
        o_res.match_end   = SLOT_W'(r_me);
    end

endmodule

### sv/byte_ring_buffer_with_pattern_search_top.sv
// ============================================================================
// byte_ring_buffer_with_pattern_search_top
// Byte ring buffer with push, pop, peek, flush, pattern locate/chop and
// decimal number parsing, built around one byte RAM.
// ============================================================================
// Usage:
//   Send one command item on s_axis (mode, byte, offset, pattern, length,
//   chop flags); one result item leaves on m_axis for every command.
//   The buffer holds at most DEPTH-1 bytes; one RAM read per cycle.
//   Path from accept to result valid on m_axis:
//     push, flush, unused mode, empty pattern, refused pop or peek: no read
//     read number on an empty buffer: no read
//     pop, peek: one registered RAM read
//     locate, chop: a scan over the stored bytes, ending when the pattern is found
//     read number: a scan from one past the head, ending at a non-number byte
//   One item is worked on at a time; the next is taken once the result has
//   moved into the output register, so a result waiting on m_axis does not
//   block the next command.
//   Reset empties the buffer (head and tail to slot 0) and drops any result
//   held in the output register. RAM contents are not cleared.
//   While m_axis is stalled the output item holds; a second finished result
//   waits inside the engine and s_axis_tready stays low until it moves on.
// ============================================================================
module byte_ring_buffer_with_pattern_search_top #(
    parameter int DEPTH       = brb_pkg::BRB_DEPTH,
    parameter int MAX_PATTERN = brb_pkg::BRB_MAX_PATTERN
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // mode, data_byte, offset, pattern, pattern_length, move_to_end, adjust_head
    input  logic [brb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // ok, data_out, number, level, match_start, match_end, 2 zero bits
    output logic [brb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_item                 w_item;
    t_result               w_res;
    logic                  w_res_valid;
    logic                  w_res_ready;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [7:0]            w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [7:0]            w_rdata;

    logic                  r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    assign w_item = s_axis_tdata;

    brb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    brb_engine #(
        .DEPTH       (DEPTH),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_ready) begin
            n_out_valid = w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out_data <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### verif/brb_response_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// brb_response_checker
// Tracks every command item that enters the ring buffer, predicts its result
// from a private copy of the ring and its pointers, and compares each result
// item that leaves, field by field, with the oldest prediction still waiting.
// ============================================================================
module brb_response_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    // mode, data_byte, offset, pattern, pattern_length, move_to_end, adjust_head
    input  logic [brb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // ok, data_out, number, level, match_start, match_end, 2 zero bits
    input  logic [brb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output int                               o_mismatches,
    output int                               o_waiting,
    output int                               o_checked,
    output int                               o_found,
    output int                               o_refused
);
    import brb_pkg::*;

    logic [BYTE_W-1:0] ring_bytes [BRB_DEPTH];
    logic [SLOT_W-1:0] head_ptr = '0;
    logic [SLOT_W-1:0] tail_ptr = '0;
    t_result           result_q [$];
    t_result           want;
    t_result           got;
    int                mismatches = 0;
    int                checked    = 0;
    int                found      = 0;
    int                refused    = 0;

    function automatic logic [SLOT_W-1:0] fill_level();
        return tail_ptr - head_ptr;
    endfunction

    function automatic logic search_pattern(input t_item cmd,
                                            output logic [SLOT_W-1:0] span_first,
                                            output logic [SLOT_W-1:0] span_last);
        int   len;
        int   lvl;
        logic hit;
        len        = (cmd.pattern_length > BRB_MAX_PATTERN) ? BRB_MAX_PATTERN
                                                            : int'(cmd.pattern_length);
        lvl        = int'(fill_level());
        span_first = '0;
        span_last  = '0;
        if (len == 0) begin
            span_first = head_ptr;
            span_last  = head_ptr - 1'b1;
            return 1'b1;
        end
        for (int s = 0; s + len <= lvl; s++) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
                if (ring_bytes[SLOT_W'(head_ptr + s + i)] != cmd.pattern[8*i +: 8])
                    hit = 1'b0;
            end
            if (hit) begin
                span_first = SLOT_W'(head_ptr + s);
                span_last  = SLOT_W'(head_ptr + s + len - 1);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // scan starts one entry past the head
    function automatic logic [NUM_W-1:0] parse_decimal();
        logic [NUM_W-1:0]  acc;
        logic              seen;
        logic              negative;
        logic              stop;
        logic [SLOT_W-1:0] p;
        logic [BYTE_W-1:0] c;
        acc      = '0;
        seen     = 1'b0;
        negative = 1'b0;
        stop     = 1'b0;
        if (head_ptr == tail_ptr)
            return '0;
        p = head_ptr + 1'b1;
        while (p != tail_ptr && !stop) begin
            c = ring_bytes[p];
            if (c == CHAR_MINUS && !seen) begin
                negative = 1'b1;
                seen     = 1'b1;
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                seen = 1'b1;
                acc  = acc * 10 + NUM_W'(c - CHAR_ZERO);
            end else if (c != CHAR_SPACE || seen) begin
                stop = 1'b1;
            end
            p = p + 1'b1;
        end
        return negative ? -acc : acc;
    endfunction

    function automatic t_result predict_command(input t_item cmd);
        t_result           r;
        logic [SLOT_W-1:0] span_first;
        logic [SLOT_W-1:0] span_last;
        logic [SLOT_W-1:0] dest;
        r = '0;
        case (cmd.mode)
            MODE_PUSH: begin
                if (fill_level() != SLOT_W'(BRB_DEPTH - 1)) begin
                    ring_bytes[tail_ptr] = cmd.data_byte;
                    tail_ptr             = tail_ptr + 1'b1;
                    r.ok                 = 1'b1;
                end else begin
                    refused++;
                end
            end
            MODE_POP: begin
                if (head_ptr != tail_ptr) begin
                    r.data_out = ring_bytes[head_ptr];
                    head_ptr   = head_ptr + 1'b1;
                    r.ok       = 1'b1;
                end
            end
            MODE_PEEK: begin
                if (cmd.offset < fill_level()) begin
                    r.data_out = ring_bytes[SLOT_W'(head_ptr + cmd.offset)];
                    r.ok       = 1'b1;
                end
            end
            MODE_FLUSH: head_ptr = tail_ptr;
            MODE_LOCATE, MODE_CHOP: begin
                if (search_pattern(cmd, span_first, span_last)) begin
                    r.ok          = 1'b1;
                    r.match_start = span_first;
                    r.match_end   = span_last;
                    found++;
                    if (cmd.mode == MODE_CHOP) begin
                        dest = cmd.move_to_end ? span_last + 1'b1 : span_first;
                        if (cmd.adjust_head)
                            head_ptr = dest;
                        else
                            tail_ptr = dest;
                    end
                end
            end
            MODE_NUMBER: r.number = parse_decimal();
            default: ;
        endcase
        r.level = fill_level();
        return r;
    endfunction

    task automatic compare_field(input string name, input longint exp_val,
                                 input longint act_val);
        if (exp_val != act_val) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_ptr = '0;
            tail_ptr = '0;
            result_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata);
                if (result_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, expected nothing actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = result_q.pop_front();
                    checked++;
                    compare_field("ok", want.ok, got.ok);
                    compare_field("data_out", want.data_out, got.data_out);
                    compare_field("number", want.number, got.number);
                    compare_field("level", want.level, got.level);
                    compare_field("match_start", want.match_start, got.match_start);
                    compare_field("match_end", want.match_end, got.match_end);
                    compare_field("pad", want.pad, got.pad);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(predict_command(t_item'(s_axis_tdata)));
        end
        o_mismatches <= mismatches;
        o_waiting    <= result_q.size();
        o_checked    <= checked;
        o_found      <= found;
        o_refused    <= refused;
    end

endmodule

### verif/tb_byte_ring_buffer_with_pattern_search_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_byte_ring_buffer_with_pattern_search_top
// Drives command items into the ring buffer: a directed pass over empty and
// edge cases, then random push bursts, number strings, pattern searches and
// chops built from recently pushed bytes, fills to full, pops, peeks and
// noise, with random stalls on both sides. The checker judges every result.
// ============================================================================
module tb_byte_ring_buffer_with_pattern_search_top;
    import brb_pkg::*;

    localparam int                ITEM_TARGET    = 1350;
    localparam int                WATCHDOG_LIMIT = 3000;
    localparam int                DRAIN_CYCLES   = 200;
    localparam logic [MODE_W-1:0] MODE_UNUSED    = 3'd7;
    localparam logic [BYTE_W-1:0] LETTER_A       = 8'h61;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // mode, data_byte, offset, pattern, pattern_length, move_to_end, adjust_head
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // ok, data_out, number, level, match_start, match_end, 2 zero bits
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int                sent    = 0;
    int                fills   = 0;
    logic              gaps_on = 1'b1;
    logic [BYTE_W-1:0] push_log [$];
    int                mismatches;
    int                waiting;
    int                checked;
    int                found;
    int                refused;
    int                quiet_cycles;
    int                pick;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    byte_ring_buffer_with_pattern_search_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    brb_response_checker u_response_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_waiting     (waiting),
        .o_checked     (checked),
        .o_found       (found),
        .o_refused     (refused)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= 24);
    end

    function automatic t_item noise_cmd(input logic [MODE_W-1:0] mode_sel);
        t_item c;
        c.mode           = mode_sel;
        c.data_byte      = BYTE_W'($urandom);
        c.offset         = OFS_W'($urandom);
        c.pattern        = {$urandom, $urandom};
        c.pattern_length = PLEN_W'($urandom);
        c.move_to_end    = 1'($urandom);
        c.adjust_head    = 1'($urandom);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        if ($urandom_range(9) < 2)
            return BYTE_W'($urandom);
        return LETTER_A + BYTE_W'($urandom_range(2));
    endfunction

    // hold valid across back-to-back items; drop it only on an idle cycle
    task automatic send_item(input t_item c);
        while (gaps_on && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        t_item c;
        c           = noise_cmd(MODE_PUSH);
        c.data_byte = b;
        send_item(c);
        push_log.push_back(b);
        if (push_log.size() > 24)
            void'(push_log.pop_front());
    endtask

    task automatic send_peek(input logic [OFS_W-1:0] ofs);
        t_item c;
        c        = noise_cmd(MODE_PEEK);
        c.offset = ofs;
        send_item(c);
    endtask

    task automatic send_pattern_cmd(input logic [MODE_W-1:0] mode_sel,
                                    input logic [PAT_W-1:0] pat,
                                    input logic [PLEN_W-1:0] len,
                                    input logic to_end, input logic on_head);
        t_item c;
        c                = noise_cmd(mode_sel);
        c.pattern        = pat;
        c.pattern_length = len;
        c.move_to_end    = to_end;
        c.adjust_head    = on_head;
        send_item(c);
    endtask

    task automatic search_recent();
        t_item c;
        int    len;
        int    start;
        c = noise_cmd(($urandom_range(4) < 3) ? MODE_LOCATE : MODE_CHOP);
        pick = $urandom_range(9);
        if (pick == 0) begin
            c.pattern_length = '0;
        end else if (pick > 1 && push_log.size() > 0) begin
            len   = $urandom_range(1, (push_log.size() < 8) ? push_log.size() : 8);
            start = $urandom_range(0, push_log.size() - len);
            for (int i = 0; i < len; i++)
                c.pattern[8*i +: 8] = push_log[start + i];
            c.pattern_length = PLEN_W'(len);
            if (len == BRB_MAX_PATTERN && $urandom_range(1))
                c.pattern_length = PLEN_W'(BRB_MAX_PATTERN + $urandom_range(1, 7));
        end
        send_item(c);
    endtask

    task automatic number_sequence();
        int digits;
        if ($urandom_range(3) != 0)
            send_item(noise_cmd(MODE_FLUSH));
        push_byte(text_byte());
        repeat ($urandom_range(3)) push_byte(CHAR_SPACE);
        if ($urandom_range(1))
            push_byte(CHAR_MINUS);
        digits = ($urandom_range(4) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 9);
        for (int k = 0; k < digits; k++) begin
            if ($urandom_range(19) == 0)
                push_byte(text_byte());
            push_byte(CHAR_ZERO + BYTE_W'($urandom_range(9)));
        end
        case ($urandom_range(3))
            0: push_byte(CHAR_SPACE);
            1: push_byte(CHAR_MINUS);
            2: push_byte(text_byte());
            default: ;
        endcase
        send_item(noise_cmd(MODE_NUMBER));
    endtask

    task automatic drain_some();
        t_item c;
        repeat ($urandom_range(1, 4)) begin
            c = noise_cmd($urandom_range(1) ? MODE_POP : MODE_PEEK);
            if ($urandom_range(3) != 0)
                c.offset = OFS_W'($urandom_range(20));
            send_item(c);
        end
    endtask

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Run stalled with %0d results still outstanding", waiting);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring
        send_item(noise_cmd(MODE_POP));
        send_peek('0);
        send_pattern_cmd(MODE_LOCATE, {$urandom, $urandom}, '0, 1'b0, 1'b0);
        send_pattern_cmd(MODE_CHOP, {$urandom, $urandom}, '0, 1'b1, 1'b1);
        send_item(noise_cmd(MODE_NUMBER));
        send_item(noise_cmd(MODE_UNUSED));
        // " -42" after a zero head byte, then an all-ones byte
        push_byte(8'h00);
        push_byte(CHAR_SPACE);
        push_byte(CHAR_MINUS);
        push_byte(CHAR_ZERO + 8'd4);
        push_byte(CHAR_ZERO + 8'd2);
        push_byte(8'hFF);
        send_item(noise_cmd(MODE_NUMBER));
        send_peek('0);
        send_peek(OFS_W'(5));
        send_peek(OFS_W'(6));
        send_peek('1);
        send_pattern_cmd(MODE_LOCATE, {48'h0, CHAR_SPACE, 8'h00}, PLEN_W'(2), 1'b0, 1'b0);
        send_pattern_cmd(MODE_LOCATE, '1, '1, 1'b0, 1'b0);
        send_pattern_cmd(MODE_LOCATE, 64'hFF, PLEN_W'(1), 1'b0, 1'b0);
        send_pattern_cmd(MODE_CHOP, {56'h0, CHAR_ZERO + 8'd4}, PLEN_W'(1), 1'b0, 1'b1);
        send_pattern_cmd(MODE_CHOP, {56'h0, CHAR_ZERO + 8'd2}, PLEN_W'(1), 1'b1, 1'b1);
        send_pattern_cmd(MODE_CHOP, {$urandom, $urandom}, '0, 1'b0, 1'b0);
        send_item(noise_cmd(MODE_POP));
        send_item(noise_cmd(MODE_FLUSH));

        while (sent < ITEM_TARGET) begin
            gaps_on <= !(sent >= 600 && sent < 850);
            pick = $urandom_range(99);
            if (pick < 22)
                repeat ($urandom_range(1, 20)) push_byte(text_byte());
            else if (pick < 34)
                number_sequence();
            else if (pick < 58)
                repeat ($urandom_range(1, 3)) search_recent();
            else if (pick < 74)
                drain_some();
            else if (pick < 92 || fills >= 4)
                send_item(noise_cmd(MODE_W'($urandom_range(7))));
            else begin
                fills++;
                repeat (BRB_DEPTH + 2) push_byte(text_byte());
            end
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands over every mode, %0d results compared,", sent, checked);
        $display("%0d pattern hits, %0d refused pushes on a full ring.", found, refused);
        if (mismatches == 0 && waiting == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
sv/brb_pkg.sv
sv/brb_ram.sv
sv/brb_engine.sv
sv/byte_ring_buffer_with_pattern_search_top.sv
verif/brb_response_checker.sv
verif/tb_byte_ring_buffer_with_pattern_search_top.sv
